// ----- rtl/core/bpa_pkg.sv -----
`default_nettype none

package bpa_pkg;

    localparam int ORD_W = 4;
    localparam int PAGE_W = 12;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOMEM    = 2'd1,
        ST_BADORDER = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/buddy_page_allocator.sv -----
// Free: done follows the S_FREE state via the done register; rejected requests show done in the next cycle.
// Allocate: S_SCAN steps up through the orders, S_POP pops the head, S_SPLIT splits once per order and then
//   finishes, and done is then shown from the done register.
// A new request is taken in the cycle that done is shown; results cannot be stalled.
// After reset every entry of the page memory is swept with busy high.
`default_nettype none

module buddy_page_allocator #(
    parameter int PAGE_COUNT = 4096,
    parameter int TOP_ORDER  = 11
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         func,
    input  wire logic [bpa_pkg::ORD_W-1:0]    req_order,
    input  wire logic [bpa_pkg::PAGE_W-1:0]   free_page,
    output logic                              done,
    output logic      [1:0]                   status,
    output logic      [bpa_pkg::PAGE_W-1:0]   page_index
);
    import bpa_pkg::*;

    localparam int AW   = $clog2(PAGE_COUNT);
    localparam int LW   = $clog2(PAGE_COUNT + 1);
    localparam int IW   = $clog2(TOP_ORDER + 1);
    localparam int SUMW = ((LW > 16) ? LW : 16) + 1;
    localparam int DW   = ORD_W + LW;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FREE  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_POP   = 6'b010000,
        S_SPLIT = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [ORD_W-1:0]  cur_reg, cur_next;
    logic [ORD_W-1:0]  want_reg, want_next;
    logic [LW-1:0]     blk_reg, blk_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [PAGE_W-1:0] index_reg, index_next;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;
    logic [DW-1:0]     mem_wdata, mem_rdata;
    logic [ORD_W-1:0]  rd_ord;
    logic [LW-1:0]     rd_link;

    logic [IW-1:0]     hd_ridx, hd_widx;
    logic [LW-1:0]     hd_rdata, hd_wdata;
    logic              hd_we;

    logic [ORD_W-1:0]  clr_ord;
    logic [ORD_W-1:0]  split_ord;
    logic [SUMW-1:0]   buddy;

    bpa_page_mem #(
        .DEPTH (PAGE_COUNT),
        .AW    (AW),
        .LW    (LW)
    ) u_page_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bpa_head_file #(
        .PAGE_COUNT (PAGE_COUNT),
        .TOP_ORDER  (TOP_ORDER),
        .LW         (LW),
        .IW         (IW)
    ) u_head_file (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (hd_ridx),
        .rd_data (hd_rdata),
        .we      (hd_we),
        .wr_idx  (hd_widx),
        .wr_data (hd_wdata)
    );

    assign rd_ord    = mem_rdata[DW-1 -: ORD_W];
    assign rd_link   = mem_rdata[LW-1:0];
    assign clr_ord   = (clr_reg == '0) ? ORD_W'(TOP_ORDER) : ORD_W'(0);
    assign split_ord = cur_reg - ORD_W'(1);
    assign buddy     = SUMW'(blk_reg) + (SUMW'(1) << split_ord);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cur_next    = cur_reg;
        want_next   = want_reg;
        blk_next    = blk_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        index_next  = index_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = '0;
        mem_wdata   = '0;
        hd_ridx     = cur_reg[IW-1:0];
        hd_we       = 1'b0;
        hd_widx     = '0;
        hd_wdata    = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = {clr_ord, LW'(PAGE_COUNT)};
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(PAGE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_FREE)
                    begin
                        if (SUMW'(free_page) < SUMW'(PAGE_COUNT))
                        begin
                            mem_re     = 1'b1;
                            mem_addr   = AW'(free_page);
                            blk_next   = LW'(free_page);
                            state_next = S_FREE;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            index_next  = '0;
                        end
                    end
                    else if (req_order > ORD_W'(TOP_ORDER))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_BADORDER;
                        index_next  = '0;
                    end
                    else
                    begin
                        cur_next   = req_order;
                        want_next  = req_order;
                        state_next = S_SCAN;
                    end
                end
            end
            S_FREE:
            begin
                hd_ridx = rd_ord[IW-1:0];
                if (rd_ord <= ORD_W'(TOP_ORDER))
                begin
                    mem_we    = 1'b1;
                    mem_addr  = blk_reg[AW-1:0];
                    mem_wdata = {rd_ord, hd_rdata};
                    hd_we     = 1'b1;
                    hd_widx   = rd_ord[IW-1:0];
                    hd_wdata  = blk_reg;
                end
                done_next   = 1'b1;
                status_next = ST_OK;
                index_next  = '0;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                hd_ridx = cur_reg[IW-1:0];
                if (hd_rdata < LW'(PAGE_COUNT))
                begin
                    blk_next   = hd_rdata;
                    mem_re     = 1'b1;
                    mem_addr   = hd_rdata[AW-1:0];
                    state_next = S_POP;
                end
                else if (cur_reg == ORD_W'(TOP_ORDER))
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOMEM;
                    index_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + ORD_W'(1);
                end
            end
            S_POP:
            begin
                hd_we      = 1'b1;
                hd_widx    = cur_reg[IW-1:0];
                hd_wdata   = rd_link;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                hd_ridx = split_ord[IW-1:0];
                if (cur_reg > want_reg)
                begin
                    if (buddy < SUMW'(PAGE_COUNT))
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = buddy[AW-1:0];
                        mem_wdata = {split_ord, hd_rdata};
                        hd_we     = 1'b1;
                        hd_widx   = split_ord[IW-1:0];
                        hd_wdata  = buddy[LW-1:0];
                    end
                    cur_next = split_ord;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_addr    = blk_reg[AW-1:0];
                    mem_wdata   = {want_reg, LW'(PAGE_COUNT)};
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    index_next  = PAGE_W'(blk_reg);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        want_reg   <= want_next;
        blk_reg    <= blk_next;
        status_reg <= status_next;
        index_reg  <= index_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign page_index = index_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bpa_page_mem.sv -----
`default_nettype none

module bpa_page_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int LW    = 13
) (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic                           re,
    input  wire logic [AW-1:0]                  addr,
    input  wire logic [bpa_pkg::ORD_W+LW-1:0]   wdata,
    output logic      [bpa_pkg::ORD_W+LW-1:0]   rdata
);
    import bpa_pkg::*;

    logic [ORD_W+LW-1:0] mem [DEPTH];
    logic [ORD_W+LW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bpa_head_file.sv -----
`default_nettype none

module bpa_head_file #(
    parameter int PAGE_COUNT = 4096,
    parameter int TOP_ORDER  = 11,
    parameter int LW         = 13,
    parameter int IW         = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [IW-1:0] rd_idx,
    output logic      [LW-1:0] rd_data,
    input  wire logic          we,
    input  wire logic [IW-1:0] wr_idx,
    input  wire logic [LW-1:0] wr_data
);

    logic [LW-1:0] head_reg [TOP_ORDER+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= TOP_ORDER; i++)
            begin
                head_reg[i] <= (i == TOP_ORDER) ? LW'(0) : LW'(PAGE_COUNT);
            end
        end
        else if (we)
        begin
            head_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = head_reg[rd_idx];

endmodule

`default_nettype wire
